FILE: hw/rtl/searchable_fifo_queue_macros.svh
// ----------------------------------------------------------------------------
// searchable fifo queue assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_FIFO_QUEUE_MACROS_SVH
`define SEARCHABLE_FIFO_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SFQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfq assertion failed");

// condition must never be seen out of reset
`define SFQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sfq forbidden condition seen");

`else

`define SFQ_ASSERT(lbl, prop)
`define SFQ_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: hw/rtl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// shared sizes, codes and the cell control bundle of the searchable fifo queue
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);

  // port widths of the transaction fields
  localparam int FUNC_W   = 3;
  localparam int IO_W     = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam cnt_t FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_READ      = 3'd2,
    OP_ERASE     = 3'd3,
    OP_ERASE_ALL = 3'd4,
    OP_CHANGE    = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic  cmp;    // register match flags this cycle
    logic  act;    // apply the operation this cycle
    func_t op;
    cnt_t  count;
    word_t value;
    word_t rep;
  } ctl_t;

endpackage

FILE: hw/rtl/sfq_cell.sv
// ----------------------------------------------------------------------------
// sfq_cell
// one queue slot: holds a word, compares it, takes its right neighbour's word
// ----------------------------------------------------------------------------
module sfq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfq_pkg::cnt_t        idx,
  input  sfq_pkg::ctl_t        ctl,
  input  sfq_pkg::word_t       right_q,
  input  logic                 any_in,
  output sfq_pkg::word_t       q,
  output sfq_pkg::word_t       q_nxt,
  output logic                 any_out,
  output logic                 first
);

  sfq_pkg::word_t q_r;
  logic           match_r;
  logic           match_nxt;

  // match seen here or in any cell nearer the head
  assign any_out = any_in | match_r;
  assign first   = match_r & ~any_in;
  assign q       = q_r;

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp) begin
      match_nxt = (idx < ctl.count) && (q_r == ctl.value);
    end
  end

  always_comb begin
    q_nxt = q_r;
    if (ctl.act) begin
      case (ctl.op)
        sfq_pkg::OP_PUSH: begin
          if (idx == ctl.count) begin
            q_nxt = ctl.value;
          end
        end
        sfq_pkg::OP_POP: begin
          q_nxt = right_q;
        end
        sfq_pkg::OP_ERASE, sfq_pkg::OP_ERASE_ALL: begin
          if (any_out) begin
            q_nxt = right_q;
          end
        end
        sfq_pkg::OP_CHANGE: begin
          if (first) begin
            q_nxt = ctl.rep;
          end
        end
        default: begin
          q_nxt = q_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

FILE: hw/rtl/searchable_fifo_queue.sv
// ----------------------------------------------------------------------------
// searchable_fifo_queue
// ordered queue of words with push, pop, indexed read and search operations
// ----------------------------------------------------------------------------
// usage
//   in_ channel carries one operation per transaction: in_func selects push,
//   pop, read at in_position, erase first match, erase all matches or change
//   first match; in_value is the word pushed or searched for, in_replacement
//   the word written by change
//   out_ channel returns one transaction per operation: the popped or read
//   word, the head word, the entry count and a status code
//   result: registered after a compare pass across the row of cells
//   followed by an apply pass
//   no new operation is taken until the current one has finished its
//   compare and apply passes; erase all takes one compare and apply pass per
//   removed entry plus a final pass
//   in_ready is high whenever no operation is in flight, even while a
//   result is still waiting on out_ready
//   receiver stall: the apply pass holds until the output register is free,
//   queue contents do not move meanwhile
//   reset: queue empty, no result pending, ready for a transaction on the
//   first cycle after rst_n is released
// ----------------------------------------------------------------------------
`include "searchable_fifo_queue_macros.svh"

module searchable_fifo_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  // operation channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfq_pkg::FUNC_W-1:0]    in_func,
  input  logic [sfq_pkg::IO_W-1:0]      in_value,
  input  logic [sfq_pkg::IO_W-1:0]      in_replacement,
  input  logic [sfq_pkg::POS_W-1:0]     in_position,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfq_pkg::IO_W-1:0]      out_read_word,
  output logic [sfq_pkg::IO_W-1:0]      out_head_word,
  output logic [sfq_pkg::CNT_W-1:0]     out_entry_count,
  output logic [sfq_pkg::STATUS_W-1:0]  out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                        state_r, state_nxt;

  // latched operation
  sfq_pkg::func_t                op_r, op_nxt;
  sfq_pkg::word_t                val_r, val_nxt;
  sfq_pkg::word_t                rep_r, rep_nxt;
  logic [sfq_pkg::POS_W-1:0]     pos_r, pos_nxt;

  sfq_pkg::cnt_t                 cnt_r, cnt_nxt;
  logic                          found_r, found_nxt;   // erase all removed something

  // result register
  logic                          out_valid_r, out_valid_nxt;
  sfq_pkg::word_t                read_r, read_nxt;
  sfq_pkg::word_t                head_r, head_nxt;
  sfq_pkg::cnt_t                 ocnt_r, ocnt_nxt;
  sfq_pkg::status_t              status_r, status_nxt;

  logic                          accept;
  logic                          out_free;
  logic                          act;

  sfq_pkg::ctl_t                 ctl;
  sfq_pkg::word_t                cell_q   [sfq_pkg::DEPTH];
  sfq_pkg::word_t                cell_qn  [sfq_pkg::DEPTH];
  logic [sfq_pkg::DEPTH:0]       any_chain;
  logic [sfq_pkg::DEPTH-1:0]     first_vec;
  logic                          any_match;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // broadcast control to the row of cells
  assign ctl.cmp   = (state_r == S_CMP);
  assign ctl.act   = act;
  assign ctl.op    = op_r;
  assign ctl.count = cnt_r;
  assign ctl.value = val_r;
  assign ctl.rep   = rep_r;

  // ripple of match flags from head to tail picks out the first match
  assign any_chain[0] = 1'b0;
  assign any_match    = any_chain[sfq_pkg::DEPTH];

  for (genvar i = 0; i < sfq_pkg::DEPTH; i++) begin : g_cell
    sfq_pkg::word_t right_q;

    if (i < sfq_pkg::DEPTH - 1) begin : g_mid
      assign right_q = cell_q[i+1];
    end else begin : g_tail
      assign right_q = '0;
    end

    sfq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (sfq_pkg::CNT_W'(i)),
      .ctl     (ctl),
      .right_q (right_q),
      .any_in  (any_chain[i]),
      .q       (cell_q[i]),
      .q_nxt   (cell_qn[i]),
      .any_out (any_chain[i+1]),
      .first   (first_vec[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    rep_nxt       = rep_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    act           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    read_nxt      = read_r;
    head_nxt      = head_r;
    ocnt_nxt      = ocnt_r;
    status_nxt    = status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = sfq_pkg::func_t'(in_func);
          val_nxt   = sfq_pkg::word_t'(in_value);
          rep_nxt   = sfq_pkg::word_t'(in_replacement);
          pos_nxt   = in_position;
          found_nxt = 1'b0;
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        state_nxt = S_APPLY;
      end

      S_APPLY: begin
        if (out_free) begin
          // result goes out unless erase all needs another pass
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          read_nxt      = '0;
          status_nxt    = sfq_pkg::ST_OK;

          case (op_r)
            sfq_pkg::OP_PUSH: begin
              if (cnt_r >= sfq_pkg::FULL_CNT) begin
                status_nxt = sfq_pkg::ST_FULL;
              end else begin
                act     = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            sfq_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = sfq_pkg::ST_EMPTY;
              end else begin
                act      = 1'b1;
                read_nxt = cell_q[0];
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            sfq_pkg::OP_READ: begin
              if (cnt_r == '0) begin
                status_nxt = sfq_pkg::ST_EMPTY;
              end else if (32'(pos_r) >= 32'(cnt_r)) begin
                status_nxt = sfq_pkg::ST_RANGE;
              end else begin
                read_nxt = cell_q[sfq_pkg::idx_t'(pos_r)];
              end
            end
            sfq_pkg::OP_ERASE: begin
              if (cnt_r == '0) begin
                status_nxt = sfq_pkg::ST_EMPTY;
              end else if (!any_match) begin
                status_nxt = sfq_pkg::ST_NOTFOUND;
              end else begin
                act     = 1'b1;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            sfq_pkg::OP_ERASE_ALL: begin
              // a queue emptied by earlier passes still reports ok
              if (cnt_r == '0 && !found_r) begin
                status_nxt = sfq_pkg::ST_EMPTY;
              end else if (any_match) begin
                // drop the first match and search again
                act           = 1'b1;
                cnt_nxt       = cnt_r - 1'b1;
                found_nxt     = 1'b1;
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = S_CMP;
              end else if (!found_r) begin
                status_nxt = sfq_pkg::ST_NOTFOUND;
              end
            end
            sfq_pkg::OP_CHANGE: begin
              if (cnt_r == '0) begin
                status_nxt = sfq_pkg::ST_EMPTY;
              end else if (!any_match) begin
                status_nxt = sfq_pkg::ST_NOTFOUND;
              end else begin
                act = 1'b1;
              end
            end
            default: begin
              status_nxt = sfq_pkg::ST_OK;
            end
          endcase

          head_nxt = (cnt_nxt != '0) ? cell_qn[0] : '0;
          ocnt_nxt = cnt_nxt;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    rep_r    <= rep_nxt;
    pos_r    <= pos_nxt;
    read_r   <= read_nxt;
    head_r   <= head_nxt;
    ocnt_r   <= ocnt_nxt;
    status_r <= status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_word   = sfq_pkg::IO_W'(read_r);
  assign out_head_word   = sfq_pkg::IO_W'(head_r);
  assign out_entry_count = ocnt_r;
  assign out_status      = status_r;

  // fill level never passes the number of cells
  `SFQ_ASSERT_NEVER(a_cnt_range, cnt_r > sfq_pkg::FULL_CNT)
  // at most one cell sees itself as the first match
  `SFQ_ASSERT(a_first_onehot, $onehot0(first_vec))
  // fill level only moves on an apply pass
  `SFQ_ASSERT(a_cnt_only_apply, (state_r != S_APPLY) |=> (cnt_r == $past(cnt_r)))
  // a new result only appears straight after an apply pass
  `SFQ_ASSERT(a_out_after_apply, $rose(out_valid_r) |-> $past(state_r == S_APPLY))

endmodule

FILE: verif/searchable_fifo_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_fifo_queue_test
// drives push, pop, indexed read, erase, erase-all and change transactions
// into the queue under random sender gaps and receiver stalls; a mirror of
// the queue contents predicts every result, which is checked field by field
// ----------------------------------------------------------------------------
module searchable_fifo_queue_test;

  // one result transaction as the block should return it
  typedef struct {
    sfq_pkg::word_t   read_word;
    sfq_pkg::word_t   head_word;
    sfq_pkg::cnt_t    entry_count;
    sfq_pkg::status_t status;
  } outcome_t;

  // mirror of the queue contents plus the outcomes still owed by the block
  class queue_mirror;
    sfq_pkg::word_t held[$];
    outcome_t       awaited[$];
    int unsigned    bad_results;

    // apply one accepted operation to the mirror and queue its outcome
    function void note_op(sfq_pkg::func_t op, sfq_pkg::word_t word, sfq_pkg::word_t subst,
                          logic [sfq_pkg::POS_W-1:0] slot);
      outcome_t       res;
      sfq_pkg::word_t kept[$];
      int             hit;
      res.read_word = '0;
      res.status    = sfq_pkg::ST_OK;
      hit           = -1;
      // unused codes are no operation even on an empty queue
      if (op >= sfq_pkg::OP_POP && op <= sfq_pkg::OP_CHANGE && held.size() == 0) begin
        res.status = sfq_pkg::ST_EMPTY;
      end else begin
        if (op == sfq_pkg::OP_ERASE || op == sfq_pkg::OP_CHANGE) begin
          foreach (held[i]) if (hit < 0 && held[i] == word) hit = i;
        end
        case (op)
          sfq_pkg::OP_PUSH: begin
            if (held.size() >= sfq_pkg::DEPTH) res.status = sfq_pkg::ST_FULL;
            else held.push_back(word);
          end
          sfq_pkg::OP_POP: res.read_word = held.pop_front();
          sfq_pkg::OP_READ: begin
            if (int'(slot) >= held.size()) res.status = sfq_pkg::ST_RANGE;
            else res.read_word = held[slot];
          end
          sfq_pkg::OP_ERASE: begin
            if (hit < 0) res.status = sfq_pkg::ST_NOTFOUND;
            else held.delete(hit);
          end
          sfq_pkg::OP_ERASE_ALL: begin
            foreach (held[i]) if (held[i] != word) kept.push_back(held[i]);
            if (kept.size() == held.size()) res.status = sfq_pkg::ST_NOTFOUND;
            held = kept;
          end
          sfq_pkg::OP_CHANGE: begin
            if (hit < 0) res.status = sfq_pkg::ST_NOTFOUND;
            else held[hit] = subst;
          end
          default: ;
        endcase
      end
      res.head_word   = (held.size() != 0) ? held[0] : '0;
      res.entry_count = sfq_pkg::cnt_t'(held.size());
      awaited.push_back(res);
    endfunction

    // compare one accepted result with the oldest outcome owed
    function void check_result(sfq_pkg::word_t rd, sfq_pkg::word_t head, sfq_pkg::cnt_t cnt,
                               logic [sfq_pkg::STATUS_W-1:0] st);
      outcome_t want;
      if (awaited.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: read %h head %h count %0d status %0d",
                   rd, head, cnt, st);
      end else begin
        want = awaited.pop_front();
        if (rd != want.read_word || head != want.head_word ||
            cnt != want.entry_count || st != want.status) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result mismatch: expected read %h head %h count %0d status %0d,",
                     want.read_word, want.head_word, want.entry_count, want.status,
                     " got read %h head %h count %0d status %0d",
                     rd, head, cnt, st);
        end
      end
    endfunction
  endclass

  localparam int N_RANDOM = 600;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sfq_pkg::FUNC_W-1:0]    in_func = '0;
  logic [sfq_pkg::IO_W-1:0]      in_value = '0;
  logic [sfq_pkg::IO_W-1:0]      in_replacement = '0;
  logic [sfq_pkg::POS_W-1:0]     in_position = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sfq_pkg::IO_W-1:0]      out_read_word;
  logic [sfq_pkg::IO_W-1:0]      out_head_word;
  logic [sfq_pkg::CNT_W-1:0]     out_entry_count;
  logic [sfq_pkg::STATUS_W-1:0]  out_status;

  queue_mirror mirror = new();

  // small pool of words so that searches hit often
  sfq_pkg::word_t word_pool[6];
  int unsigned    burst_left = 0;

  always #5 clk = ~clk;

  searchable_fifo_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_replacement  (in_replacement),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_word   (out_read_word),
    .out_head_word   (out_head_word),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  // offer one operation, hold it until accepted, then maybe idle
  // called at a rising edge; every assignment to a port is nonblocking at an edge
  task automatic send_op(sfq_pkg::func_t op, sfq_pkg::word_t word, sfq_pkg::word_t subst,
                         logic [sfq_pkg::POS_W-1:0] slot);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_func        <= op;
    in_value       <= word;
    in_replacement <= subst;
    in_position    <= slot;
    do @(posedge clk); while (!in_ready);
    mirror.note_op(op, word, subst, slot);
    // bursts of back-to-back transactions separated by short idle gaps
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // mostly words from the pool, now and then a fully random one
  function automatic sfq_pkg::word_t pick_word();
    if ($urandom_range(0, 9) < 8) return word_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // receiver: checks every result transaction and stalls on its own pattern
  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    int unsigned stall_left;
    int unsigned results_seen;
    cyc          = 0;
    mode         = 0;
    stall_left   = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        mirror.check_result(out_read_word, out_head_word, out_entry_count, out_status);
        results_seen++;
        // long hold-off while the sender keeps offering, so the block backs up
        if (results_seen == 150 || results_seen == 450) stall_left = 120;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;                          // no stalls at all
          1: out_ready <= ($urandom_range(0, 3) != 0);   // light stalling
          2: out_ready <= ($urandom_range(0, 9) < 3);    // heavy stalling
          default: out_ready <= ~out_ready;              // ready alternates high and low
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned    push_weight;
    sfq_pkg::func_t op;
    sfq_pkg::word_t mix_word;
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 6; i++) word_pool[i] = $urandom;
    mix_word = 32'h5A5A_A5A5;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // every operation but push on an empty queue
    send_op(sfq_pkg::OP_POP,       '0, '0, '0);
    send_op(sfq_pkg::OP_READ,      '0, '0, '0);
    send_op(sfq_pkg::OP_ERASE,     '0, '0, '0);
    send_op(sfq_pkg::OP_ERASE_ALL, '0, '0, '0);
    send_op(sfq_pkg::OP_CHANGE,    '0, '1, '0);
    // extreme words, duplicates included
    send_op(sfq_pkg::OP_PUSH,      '0, '1, '1);
    send_op(sfq_pkg::OP_PUSH,      '1, '0, '0);
    send_op(sfq_pkg::OP_PUSH,      '0, '0, '0);
    // indexed read at the last entry, just past it, and at the top index
    send_op(sfq_pkg::OP_READ,      '1, '1, 4'd2);
    send_op(sfq_pkg::OP_READ,      '0, '0, 4'd3);
    send_op(sfq_pkg::OP_READ,      '0, '0, 4'hF);
    // change hits the head, the first of two matches
    send_op(sfq_pkg::OP_CHANGE,    '0, mix_word, '0);
    // erase-all of the remaining match, then a miss
    send_op(sfq_pkg::OP_ERASE_ALL, '0, '0, '0);
    send_op(sfq_pkg::OP_ERASE_ALL, '0, '0, '0);
    // misses for erase and change
    send_op(sfq_pkg::OP_ERASE,     32'h0000_0007, '0, '0);
    send_op(sfq_pkg::OP_CHANGE,    32'h0000_0007, '1, '0);
    // erase the last entry, then erase-all that takes the head and empties
    send_op(sfq_pkg::OP_ERASE,     '1, '0, '0);
    send_op(sfq_pkg::OP_PUSH,      mix_word, '0, '0);
    send_op(sfq_pkg::OP_ERASE_ALL, mix_word, '0, '0);
    // pop returns the only word
    send_op(sfq_pkg::OP_PUSH,      32'h8000_0001, '0, '0);
    send_op(sfq_pkg::OP_POP,       '1, '1, '1);

    // random part: phases lean towards filling, draining or balance
    push_weight = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_weight = 85;   // fill up to full and past it
          1: push_weight = 15;   // drain to empty
          2: push_weight = 35;
          default: push_weight = 50;
        endcase
        for (int i = 2; i < 6; i++) word_pool[i] = $urandom;
      end
      if ($urandom_range(0, 99) < push_weight) op = sfq_pkg::OP_PUSH;
      else op = sfq_pkg::func_t'($urandom_range(int'(sfq_pkg::OP_POP),
                                                int'(sfq_pkg::OP_CHANGE)));
      send_op(op, pick_word(), pick_word(), sfq_pkg::POS_W'($urandom_range(0, 15)));
    end

    if (in_valid) in_valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    // let any stray result show itself
    repeat (40) @(posedge clk);
    if (mirror.bad_results == 0 && mirror.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: searchable_fifo_queue.f
+incdir+hw/rtl
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_cell.sv
hw/rtl/searchable_fifo_queue.sv
verif/searchable_fifo_queue_test.sv
